@@ src/i4dot_pkg.sv @@
`timescale 1ns / 1ps

package i4dot_pkg;

    localparam int SCALE_FRAC_BITS_DEF = 12;
    localparam int RESULT_FRAC_BITS    = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int BLOCK_ELEMS  = 32;
    localparam int HALF_ELEMS   = BLOCK_ELEMS / 2;
    localparam int NIBBLE_SHIFT = 4;
    localparam logic [3:0] NIBBLE_MASK   = 4'hf;
    localparam logic [3:0] NIBBLE_OFFSET = 4'h8;

    localparam int ACT_W   = 8;
    localparam int WGT_W   = 4;
    localparam int PROD_W  = ACT_W + WGT_W;
    localparam int ISUM_W  = PROD_W + 5;
    localparam int SCALE_W = 16;
    localparam int SPROD_W = 2 * SCALE_W;
    localparam int TERM_W  = ISUM_W + SPROD_W;
    localparam int BIAS_W  = 48;
    localparam int ACC_W   = 64;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ISUM_W-1:0]  isum;
        logic signed [SPROD_W-1:0] scale_prod;
        logic signed [BIAS_W-1:0]  bias;
        logic                      last;
    } i4dot_job_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    hit;
    } i4dot_sat_t;

    function automatic i4dot_sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                           input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        i4dot_sat_t r;
        s = a + b;
        r.value = s;
        r.hit = 1'b0;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]))
        begin
            r.hit = 1'b1;
            r.value = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return r;
    endfunction

endpackage

@@ src/i4dot_if.sv @@
`timescale 1ns / 1ps

interface i4dot_in_if import i4dot_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [63:0]               act_bytes_a;
    logic [63:0]               act_bytes_b;
    logic [63:0]               act_bytes_c;
    logic [63:0]               act_bytes_d;
    logic [63:0]               weight_bytes_lo;
    logic [63:0]               weight_bytes_hi;
    logic signed [SCALE_W-1:0] act_scale;
    logic signed [SCALE_W-1:0] weight_scale;
    logic signed [BIAS_W-1:0]  bias_value;
    logic                      last_block;

    modport source (output valid, act_bytes_a, act_bytes_b, act_bytes_c, act_bytes_d,
                    weight_bytes_lo, weight_bytes_hi, act_scale, weight_scale,
                    bias_value, last_block, input ready);
    modport sink (input valid, act_bytes_a, act_bytes_b, act_bytes_c, act_bytes_d,
                  weight_bytes_lo, weight_bytes_hi, act_scale, weight_scale,
                  bias_value, last_block, output ready);
endinterface

interface i4dot_out_if import i4dot_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] result_value;
    logic                    saturated;

    modport source (output valid, result_value, saturated, input ready);
    modport sink (input valid, result_value, saturated, output ready);
endinterface

@@ src/int8_int4_block_scaled_dot.sv @@
`timescale 1ns / 1ps
// a last-block request passes the queue, then the p, f and output registers before its result shows
// one block per cycle when not stalled; the 64-bit accumulator add is the only recurrent path
// a stalled result stalls the back stages; the queue keeps taking requests until full
// reset (rst_n, async, active low) clears the queue, accumulator, saturation flag,
// all valid flags and bias_enable

module int8_int4_block_scaled_dot import i4dot_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    i4dot_in_if.sink    in_ch,
    i4dot_out_if.source out_ch
);

    logic        bias_enable_reg, bias_enable_next;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    i4dot_job_t  push_job;
    i4dot_job_t  head_job;

    assign bias_enable_next = cfg_write_en ? cfg_write_data : bias_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bias_enable_reg <= 1'b0;
        else
            bias_enable_reg <= bias_enable_next;
    end

    i4dot_front u_front
    (
        .in_ch (in_ch),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    i4dot_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .head      (head_job),
        .full      (full),
        .empty     (empty)
    );

    i4dot_back #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .bias_enable (bias_enable_reg),
        .head        (head_job),
        .empty       (empty),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

@@ src/i4dot_front.sv @@
`timescale 1ns / 1ps

module i4dot_front import i4dot_pkg::*;
(
    i4dot_in_if.sink    in_ch,
    input  logic        full,
    output logic        push,
    output i4dot_job_t  job
);

    logic [BLOCK_ELEMS*ACT_W-1:0]     acts;
    logic [HALF_ELEMS*ACT_W-1:0]      wbytes;
    logic signed [PROD_W-1:0]         prod [BLOCK_ELEMS];
    logic signed [PROD_W:0]           sum16 [16];
    logic signed [PROD_W+1:0]         sum8 [8];
    logic signed [PROD_W+2:0]         sum4 [4];
    logic signed [PROD_W+3:0]         sum2 [2];

    assign acts   = {in_ch.act_bytes_d, in_ch.act_bytes_c, in_ch.act_bytes_b, in_ch.act_bytes_a};
    assign wbytes = {in_ch.weight_bytes_hi, in_ch.weight_bytes_lo};

    // offset-8 nibble minus 8 is the nibble with its top bit flipped
    always_comb
    begin
        logic [7:0]               wb;
        logic signed [WGT_W-1:0]  wlo;
        logic signed [WGT_W-1:0]  whi;
        for (int b = 0; b < HALF_ELEMS; b++)
        begin
            wb  = wbytes[8*b +: 8];
            wlo = $signed((wb[3:0] & NIBBLE_MASK) ^ NIBBLE_OFFSET);
            whi = $signed((wb[7:NIBBLE_SHIFT] & NIBBLE_MASK) ^ NIBBLE_OFFSET);
            prod[b]              = $signed(acts[ACT_W*b +: ACT_W]) * wlo;
            prod[b + HALF_ELEMS] = $signed(acts[ACT_W*(b + HALF_ELEMS) +: ACT_W]) * whi;
        end
    end

    // adder tree
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            sum16[i] = PROD_W'(0) + prod[2*i] + prod[2*i+1];
        for (int i = 0; i < 8; i++)
            sum8[i] = sum16[2*i] + sum16[2*i+1];
        for (int i = 0; i < 4; i++)
            sum4[i] = sum8[2*i] + sum8[2*i+1];
        for (int i = 0; i < 2; i++)
            sum2[i] = sum4[2*i] + sum4[2*i+1];
    end

    always_comb
    begin
        job.isum       = sum2[0] + sum2[1];
        job.scale_prod = in_ch.act_scale * in_ch.weight_scale;
        job.bias       = in_ch.bias_value;
        job.last       = in_ch.last_block;
    end

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

endmodule

@@ src/i4dot_fifo.sv @@
`timescale 1ns / 1ps

module i4dot_fifo import i4dot_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  i4dot_job_t  push_data,
    input  logic        pop,
    output i4dot_job_t  head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i4dot_job_t         queue_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/i4dot_back.sv @@
`timescale 1ns / 1ps

module i4dot_back import i4dot_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         bias_enable,
    input  i4dot_job_t   head,
    input  logic         empty,
    output logic         pop,
    i4dot_out_if.source  out_ch
);

    localparam int PROD_FRAC = 2 * SCALE_FRAC_BITS;
    localparam int LSHIFT    = (PROD_FRAC <= RESULT_FRAC_BITS) ? RESULT_FRAC_BITS - PROD_FRAC : 0;
    localparam int RSHIFT    = (PROD_FRAC <= RESULT_FRAC_BITS) ? 0 : PROD_FRAC - RESULT_FRAC_BITS;

    logic                      advance;

    logic                      p_valid_reg, p_valid_next;
    logic signed [TERM_W-1:0]  p_term_reg, p_term_next;
    logic signed [BIAS_W-1:0]  p_bias_reg;
    logic                      p_last_reg;

    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      sat_reg, sat_next;

    logic                      f_valid_reg, f_valid_next;
    logic signed [ACC_W-1:0]   f_value_reg, f_value_next;
    logic                      f_sat_reg, f_sat_next;
    logic signed [BIAS_W-1:0]  f_bias_reg;

    logic                      out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]   out_value_reg, out_value_next;
    logic                      out_sat_reg, out_sat_next;

    logic signed [ACC_W-1:0]   term_ext;
    logic signed [ACC_W-1:0]   aligned;
    i4dot_sat_t                acc_sum;
    i4dot_sat_t                bias_sum;

    assign advance = !out_valid_reg || out_ch.ready;
    assign pop     = advance && !empty;

    // stage 1: scale the block sum
    always_comb
    begin
        p_valid_next = advance ? pop : p_valid_reg;
        p_term_next  = head.isum * head.scale_prod;
    end

    // stage 2: align and accumulate
    always_comb
    begin
        term_ext = ACC_W'(p_term_reg);
        if (PROD_FRAC <= RESULT_FRAC_BITS)
            aligned = term_ext <<< LSHIFT;
        else
            aligned = term_ext >>> RSHIFT;
        acc_sum = sat_add(acc_reg, aligned);

        acc_next     = acc_reg;
        sat_next     = sat_reg;
        f_valid_next = f_valid_reg;
        f_value_next = acc_sum.value;
        f_sat_next   = sat_reg || acc_sum.hit;
        if (advance)
        begin
            f_valid_next = p_valid_reg && p_last_reg;
            if (p_valid_reg)
            begin
                if (p_last_reg)
                begin
                    acc_next = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    acc_next = acc_sum.value;
                    sat_next = sat_reg || acc_sum.hit;
                end
            end
        end
    end

    // stage 3: optional bias into the output register
    always_comb
    begin
        bias_sum = sat_add(f_value_reg, ACC_W'(f_bias_reg));
        out_valid_next = out_valid_reg;
        out_value_next = f_value_reg;
        out_sat_next   = f_sat_reg;
        if (bias_enable)
        begin
            out_value_next = bias_sum.value;
            out_sat_next   = f_sat_reg || bias_sum.hit;
        end
        if (advance)
            out_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            f_valid_reg   <= f_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_term_reg <= p_term_next;
            p_bias_reg <= head.bias;
            p_last_reg <= head.last;
        end
        if (advance && p_valid_reg && p_last_reg)
        begin
            f_value_reg <= f_value_next;
            f_sat_reg   <= f_sat_next;
            f_bias_reg  <= p_bias_reg;
        end
        if (advance && f_valid_reg)
        begin
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.saturated    = out_sat_reg;

endmodule

@@ src/i4dot_checker.sv @@
`timescale 1ns / 1ps

module i4dot_checker import i4dot_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    in_last,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ACC_W-1:0] out_value,
    input logic                    out_sat
);

    logic [7:0] pending_reg, pending_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready && in_last;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
            pending_next = pending_reg + 1'b1;
        else if (out_take && !in_take)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_sat))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without a last-block request");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && pending_reg == '0 |-> !out_valid)
        else $error("result ahead of its last-block request");

endmodule

bind int8_int4_block_scaled_dot i4dot_checker u_i4dot_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_block),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.result_value),
    .out_sat   (out_ch.saturated)
);

@@ test/int8_int4_block_scaled_dot_tb.sv @@
`timescale 1ns / 1ps

module int8_int4_block_scaled_dot_tb;
    import i4dot_pkg::*;

    localparam int SCALE_FRAC = SCALE_FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 120;
    localparam int SEG_ITEMS = 215;
    localparam int PRESSURE_ITEMS = 40;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam logic signed [SCALE_W-1:0] UNIT_SCALE = 16'sh1000;
    localparam logic [5:0] SEG_BIAS = 6'b101010;

    typedef struct packed {
        logic [63:0]               act_a;
        logic [63:0]               act_b;
        logic [63:0]               act_c;
        logic [63:0]               act_d;
        logic [63:0]               wt_lo;
        logic [63:0]               wt_hi;
        logic signed [SCALE_W-1:0] a_scale;
        logic signed [SCALE_W-1:0] w_scale;
        logic signed [BIAS_W-1:0]  bias;
        logic                      last;
    } block_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    sat;
    } dot_result_t;

    typedef struct packed {
        block_t                  blk;
        logic                    bias_on;
        logic                    typed;
        logic signed [ACC_W-1:0] exp_value;
        logic                    exp_sat;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    i4dot_in_if  in_ch ();
    i4dot_out_if out_ch ();

    int8_int4_block_scaled_dot #(
        .SCALE_FRAC_BITS(SCALE_FRAC),
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    logic signed [ACC_W-1:0] run_acc;
    bit                      run_clamped;
    bit                      bias_on;

    dot_result_t pending_dots [$];
    dir_row_t    dir_rows [$];
    dot_result_t want;
    int          errors;
    int unsigned cycle_cnt;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [ACC_W-1:0] clamp_add(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b,
                                                          output bit hit);
        logic signed [ACC_W:0] wide;
        wide = a + b;
        hit = 1'b0;
        if (wide > ACC_MAX)
        begin
            hit = 1'b1;
            return ACC_MAX;
        end
        if (wide < ACC_MIN)
        begin
            hit = 1'b1;
            return ACC_MIN;
        end
        return wide[ACC_W-1:0];
    endfunction

    // scaled block sum aligned to 24 fraction bits
    function automatic logic signed [ACC_W-1:0] block_term(input block_t blk);
        logic [255:0] acts;
        logic [127:0] wts;
        int a_lo;
        int a_hi;
        int w_lo;
        int w_hi;
        longint isum;
        longint sprod;
        longint term;
        acts = {blk.act_d, blk.act_c, blk.act_b, blk.act_a};
        wts = {blk.wt_hi, blk.wt_lo};
        isum = 0;
        for (int k = 0; k < HALF_ELEMS; k++)
        begin
            a_lo = int'($signed(acts[8*k +: 8]));
            a_hi = int'($signed(acts[8*(k+HALF_ELEMS) +: 8]));
            w_lo = int'(wts[8*k +: NIBBLE_SHIFT]) - int'(NIBBLE_OFFSET);
            w_hi = int'(wts[8*k+NIBBLE_SHIFT +: NIBBLE_SHIFT]) - int'(NIBBLE_OFFSET);
            isum += longint'(a_lo * w_lo + a_hi * w_hi);
        end
        sprod = longint'($signed(blk.a_scale)) * longint'($signed(blk.w_scale));
        term = isum * sprod;
        if (2 * SCALE_FRAC <= RESULT_FRAC_BITS)
            term = term <<< (RESULT_FRAC_BITS - 2 * SCALE_FRAC);
        else
            term = term >>> (2 * SCALE_FRAC - RESULT_FRAC_BITS);
        return term;
    endfunction

    task automatic absorb(input block_t blk, input bit typed,
                          input logic signed [ACC_W-1:0] ev, input bit es);
        dot_result_t r;
        bit hit;
        run_acc = clamp_add(run_acc, block_term(blk), hit);
        run_clamped |= hit;
        if (blk.last)
        begin
            r.value = run_acc;
            r.sat = run_clamped;
            if (bias_on)
            begin
                r.value = clamp_add(run_acc, longint'($signed(blk.bias)), hit);
                r.sat |= hit;
            end
            if (typed)
            begin
                r.value = ev;
                r.sat = es;
            end
            pending_dots.push_back(r);
            run_acc = '0;
            run_clamped = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int tx_gap();
        return tx_idle_on ? pick_gap() : 0;
    endfunction

    function automatic logic [63:0] rand_act_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0)
            for (int k = 0; k < 8; k++)
                case ($urandom_range(0, 3))
                    0: w[8*k +: 8] = 8'h80;
                    1: w[8*k +: 8] = 8'h7f;
                    default: ;
                endcase
        return w;
    endfunction

    function automatic logic [63:0] rand_wt_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0)
            for (int k = 0; k < 8; k++)
                case ($urandom_range(0, 3))
                    0: w[8*k +: 8] = 8'h00;
                    1: w[8*k +: 8] = 8'hff;
                    2: w[8*k +: 8] = 8'h88;
                    default: ;
                endcase
        return w;
    endfunction

    function automatic logic signed [SCALE_W-1:0] rand_scale();
        logic signed [SCALE_W-1:0] s;
        s = SCALE_W'($urandom);
        case ($urandom_range(0, 9))
            5: s = 16'sh8000;
            6: s = 16'sh7fff;
            7: s = '0;
            8, 9: s = UNIT_SCALE + $signed(16'($urandom_range(0, 255))) - 16'sd128;
            default: ;
        endcase
        return s;
    endfunction

    function automatic block_t rand_block(input bit last);
        block_t blk;
        blk.act_a = rand_act_word();
        blk.act_b = rand_act_word();
        blk.act_c = rand_act_word();
        blk.act_d = rand_act_word();
        blk.wt_lo = rand_wt_word();
        blk.wt_hi = rand_wt_word();
        blk.a_scale = rand_scale();
        blk.w_scale = rand_scale();
        blk.bias = BIAS_W'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: blk.bias = {1'b0, {(BIAS_W-1){1'b1}}};
            1: blk.bias = {1'b1, {(BIAS_W-1){1'b0}}};
            default: ;
        endcase
        blk.last = last;
        return blk;
    endfunction

    task automatic add_row(input logic [63:0] a, input logic [63:0] b,
                           input logic [63:0] c, input logic [63:0] d,
                           input logic [63:0] wl, input logic [63:0] wh,
                           input logic signed [SCALE_W-1:0] sa,
                           input logic signed [SCALE_W-1:0] sw,
                           input logic signed [BIAS_W-1:0] bias, input bit last,
                           input bit bon, input bit typed,
                           input logic signed [ACC_W-1:0] ev, input bit es);
        dir_row_t row;
        row.blk = '{a, b, c, d, wl, wh, sa, sw, bias, last};
        row.bias_on = bon;
        row.typed = typed;
        row.exp_value = ev;
        row.exp_sat = es;
        dir_rows.push_back(row);
    endtask

    // offer one request and run the predictor once it is taken
    task automatic offer(input block_t blk, input int gap, input bit typed,
                         input logic signed [ACC_W-1:0] ev, input bit es);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.act_bytes_a <= blk.act_a;
        in_ch.act_bytes_b <= blk.act_b;
        in_ch.act_bytes_c <= blk.act_c;
        in_ch.act_bytes_d <= blk.act_d;
        in_ch.weight_bytes_lo <= blk.wt_lo;
        in_ch.weight_bytes_hi <= blk.wt_hi;
        in_ch.act_scale <= blk.a_scale;
        in_ch.weight_scale <= blk.w_scale;
        in_ch.bias_value <= blk.bias;
        in_ch.last_block <= blk.last;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        absorb(blk, typed, ev, es);
    endtask

    // only while idle: no request offered, no result pending
    task automatic set_bias_enable(input bit en);
        in_ch.valid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= en;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        bias_on = en;
    endtask

    // result side
    initial
    begin : rx_side
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (rx_idle_on)
                stall = pick_gap();
            else
                stall = 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_dots.size() == 0)
            begin
                $display("%0t: result with no request pending: expected none, got value %0d sat %0b",
                         $time, out_ch.result_value, out_ch.saturated);
                errors++;
            end
            else
            begin
                want = pending_dots.pop_front();
                if (out_ch.result_value !== want.value)
                begin
                    $display("%0t: result_value mismatch: expected %0d, got %0d",
                             $time, want.value, out_ch.result_value);
                    errors++;
                end
                if (out_ch.saturated !== want.sat)
                begin
                    $display("%0t: saturated mismatch: expected %0b, got %0b",
                             $time, want.sat, out_ch.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("int8_int4_block_scaled_dot_tb: done, errors");
            $finish;
        end
    end

    initial
    begin : stim
        int len;
        int sent;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.act_bytes_a = '0;
        in_ch.act_bytes_b = '0;
        in_ch.act_bytes_c = '0;
        in_ch.act_bytes_d = '0;
        in_ch.weight_bytes_lo = '0;
        in_ch.weight_bytes_hi = '0;
        in_ch.act_scale = '0;
        in_ch.weight_scale = '0;
        in_ch.bias_value = '0;
        in_ch.last_block = 1'b0;
        run_acc = '0;
        run_clamped = 1'b0;
        bias_on = 1'b0;
        errors = 0;
        cycle_cnt = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_off_req = 1'b0;

        // zero data, unit weights, full-scale extremes
        add_row('0, '0, '0, '0, '0, '0, UNIT_SCALE, UNIT_SCALE, '0, 1, 0, 1, 64'sd0, 0);
        add_row(64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101,
                64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101,
                64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999,
                UNIT_SCALE, UNIT_SCALE, '0, 1, 0, 1, 64'sd536870912, 0);
        add_row(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
                64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, '0, '0,
                16'sh8000, 16'sh8000, '0, 1, 0, 1, 64'sd35184372088832, 0);
        add_row(64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f,
                64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f,
                64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                16'sh7fff, 16'sh8000, '0, 1, 0, 0, 64'sd0, 0);
        // nibble pairing, low and high ends of the block
        add_row(64'h01, '0, 64'h03, '0, 64'h8888_8888_8888_88ba, 64'h8888_8888_8888_8888,
                UNIT_SCALE, UNIT_SCALE, '0, 1, 0, 1, 64'sd184549376, 0);
        add_row('0, 64'h0500_0000_0000_0000, '0, 64'hfe00_0000_0000_0000,
                64'h8888_8888_8888_8888, 64'hc988_8888_8888_8888,
                UNIT_SCALE, UNIT_SCALE, '0, 1, 0, 1, -64'sd50331648, 0);
        // row of three blocks
        add_row(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h8000_7fff_0180_ff7f,
                64'h55aa_33cc_0ff0_9966, 64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0,
                16'sh0c00, 16'shec00, '0, 0, 0, 0, 64'sd0, 0);
        add_row(64'hffff_0000_ffff_0000, 64'h1234_5678_9abc_def0, 64'h7f80_7f80_7f80_7f80,
                64'h0000_ffff_0000_ffff, 64'hf0f0_0f0f_a5a5_5a5a, 64'h1111_2222_3333_4444,
                16'sh8000, 16'sh7fff, '0, 0, 0, 0, 64'sd0, 0);
        add_row(64'h0102_0304_0506_0708, 64'hf8f7_f6f5_f4f3_f2f1, 64'h1020_3040_5060_7080,
                64'h90a0_b0c0_d0e0_f000, 64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988,
                16'sh0001, 16'shffff, 48'sh1234_5678_9abc, 1, 0, 0, 64'sd0, 0);
        // zero scale, negative scale
        add_row(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
                64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, '0, '0,
                16'sh0000, 16'sh7fff, '0, 1, 0, 1, 64'sd0, 0);
        add_row(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
                64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
                64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                UNIT_SCALE, 16'shf000, '0, 1, 0, 1, 64'sd481036337152, 0);
        // bias ignored when off, then bias extremes
        add_row('0, '0, '0, '0, '0, '0, UNIT_SCALE, UNIT_SCALE, 48'sh7fff_ffff_ffff,
                1, 0, 1, 64'sd0, 0);
        add_row('0, '0, '0, '0, '0, '0, UNIT_SCALE, UNIT_SCALE, 48'sh7fff_ffff_ffff,
                1, 1, 1, 64'sd140737488355327, 0);
        add_row('0, '0, '0, '0, '0, '0, UNIT_SCALE, UNIT_SCALE, 48'sh8000_0000_0000,
                1, 1, 1, -64'sd140737488355328, 0);
        add_row(64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101,
                64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101,
                64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999,
                UNIT_SCALE, UNIT_SCALE, 48'sh00ff_ffff_ffff, 1, 1, 0, 64'sd0, 0);
        // bias on a middle block has no effect
        add_row(64'h7f01_80fe_0203_fdfc, 64'h0a0b_0c0d_f0f1_f2f3, 64'h4040_c0c0_2020_e0e0,
                64'h8181_7e7e_0101_ffff, 64'h3c3c_c3c3_a5a5_5a5a, 64'h0000_ffff_8888_7777,
                16'sh2000, 16'shd000, 48'sh7fff_ffff_ffff, 0, 1, 0, 64'sd0, 0);
        add_row(64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222, 64'hdddd_dddd_dddd_dddd,
                64'heeee_eeee_eeee_eeee, 64'h4567_89ab_cdef_0123, 64'hba98_7654_3210_fedc,
                16'sh7fff, 16'sh7fff, 48'shffff_ffff_ffff, 1, 1, 0, 64'sd0, 0);
        add_row(64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f,
                64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f, '0, '0,
                16'shffff, 16'sh8000, 48'sh5555_5555_5555, 1, 0, 0, 64'sd0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_bias_enable(1'b0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].bias_on != bias_on)
                set_bias_enable(dir_rows[i].bias_on);
            offer(dir_rows[i].blk, tx_gap(), dir_rows[i].typed,
                  dir_rows[i].exp_value, dir_rows[i].exp_sat);
        end

        // random rows
        for (int seg = 0; seg < 6; seg++)
        begin
            set_bias_enable(SEG_BIAS[seg]);
            tx_idle_on = (seg != 2);
            rx_idle_on = (seg != 2) && (seg != 4);
            if (seg == 3)
            begin
                hold_off_req = 1'b1;
                for (int k = 0; k < PRESSURE_ITEMS; k++)
                    offer(rand_block(1'b1), 0, 1'b0, '0, 1'b0);
            end
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(8, 24);
                else
                    len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    offer(rand_block(k == len - 1), tx_gap(), 1'b0, '0, 1'b0);
                sent += len;
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("int8_int4_block_scaled_dot_tb: done, clean");
        else
            $display("int8_int4_block_scaled_dot_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/i4dot_pkg.sv
src/i4dot_if.sv
src/i4dot_front.sv
src/i4dot_fifo.sv
src/i4dot_back.sv
src/int8_int4_block_scaled_dot.sv
src/i4dot_checker.sv
test/int8_int4_block_scaled_dot_tb.sv
